// ===== src/dccpr_pkg.sv =====
package dccpr_pkg;

   // register indexes on the csr channel
   localparam logic CSR_OWN_ADDRESS      = 1'b0;
   localparam logic CSR_OWN_ADDRESS_KIND = 1'b1;

   // address kinds
   localparam logic [1:0] KIND_SHORT     = 2'd0;
   localparam logic [1:0] KIND_LONG      = 2'd1;
   localparam logic [1:0] KIND_BROADCAST = 2'd2;
   localparam logic [1:0] KIND_IDLE      = 2'd3;

   // input actions
   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_END  = 1'b1;

   localparam logic [13:0] OWN_ADDRESS_RESET = 14'd3;

   localparam logic [7:0] BYTE_BROADCAST = 8'h00;
   localparam logic [7:0] BYTE_IDLE      = 8'hFF;
   localparam logic [7:0] LONG_FIRST     = 8'hC0;
   localparam logic [7:0] LONG_LAST      = 8'hE7;
   localparam logic [7:0] LONG_HI_MASK   = 8'h3F;

   localparam logic [7:0] OP_CV_SHORT   = 8'h3F;
   localparam logic [7:0] OP_ANALOG     = 8'h3D;
   localparam logic [7:0] OP_CONSIST    = 8'hC0;
   localparam logic [7:0] OP_BIN_SHORT  = 8'hDD;
   localparam logic [7:0] OP_FUNC_LO    = 8'hD8;
   localparam logic [7:0] OP_FUNC_HI    = 8'hDF;
   localparam logic [7:0] OP_CV_VERIFY  = 8'hE4;
   localparam logic [7:0] OP_CV_WRITE   = 8'hEC;
   localparam logic [7:0] OP_CV_BIT     = 8'hE8;

   // address length in bytes from the first byte, 0 when not a decoder packet
   function automatic logic [1:0] addr_len(input logic [7:0] b0);
      logic [1:0] len;
      len = 2'd0;
      if (b0[7] == 1'b0 || b0 == BYTE_IDLE) begin
         len = 2'd1;
      end else if (b0 >= LONG_FIRST && b0 <= LONG_LAST) begin
         len = 2'd2;
      end
      return len;
   endfunction

   // instruction length from its opcode, 0 when it cannot be sized
   function automatic logic [1:0] instr_len(input logic [7:0] op);
      logic [1:0] len;
      len = 2'd0;
      if (op[7:4] == 4'h1) begin
         len = 2'd2;
      end else if (op[7:6] == 2'b01) begin
         len = 2'd1;
      end else if (op[7:5] == 3'b001) begin
         if (op == OP_CV_SHORT) len = 2'd2;
         else if (op == OP_ANALOG) len = 2'd3;
      end else if (op[7:5] == 3'b100 || op[7:5] == 3'b101) begin
         len = 2'd1;
      end else if (op[7:5] == 3'b110) begin
         if (op == OP_CONSIST) len = 2'd3;
         else if (op == OP_BIN_SHORT) len = 2'd2;
         else if (op >= OP_FUNC_LO && op <= OP_FUNC_HI) len = 2'd2;
      end else if (op[7:5] == 3'b111) begin
         if (op[4] == 1'b1) len = 2'd2;
         else if (op == OP_CV_VERIFY || op == OP_CV_BIT || op == OP_CV_WRITE) len = 2'd3;
      end
      return len;
   endfunction

endpackage

// ===== src/dcc_packet_recognizer_arm.sv =====
// the rsp word is registered and appears in the cycle after its req word is accepted
// throughput: one word per cycle while the rsp side is not stalled; the packet state is updated in the same cycle
//   the word is taken, and a single output register parts the two sides
// reset (synchronous, active high) empties the output register, clears the
//   packet count, xor, armed flag and half toggle, and loads address 3, short kind
module dcc_packet_recognizer_arm
   import dccpr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] packet_byte
   input  logic [1:0]  req_tuser,   // [0] action, [1] starts_packet
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] adr_payload
   output logic [2:0]  rsp_tuser,   // [0] armed_now, [1] respond, [2] adr_low_half
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [13:0] csr_data
);

   logic [13:0] own_addr_ff;
   logic [1:0]  own_kind_ff;
   logic [7:0]  header_ff [3];
   logic [7:0]  header_in [3];
   logic [2:0]  count_ff, count_in;
   logic [7:0]  xor_ff, xor_in;
   logic        armed_ff, armed_in;
   logic        toggle_ff, toggle_in;
   logic        held_half_ff, held_half_in;
   logic [7:0]  held_payload_ff, held_payload_in;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_tdata_ff, rsp_tdata_in;
   logic [2:0]  rsp_tuser_ff, rsp_tuser_in;

   logic        accept;
   logic        action;
   logic        starts;
   logic [7:0]  b;
   logic        first;
   logic        armed_base;
   logic [1:0]  al;
   logic [1:0]  il1, il2;
   logic        complete;
   logic [13:0] pkt_addr;
   logic [1:0]  pkt_kind;
   logic        arm;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign action     = req_tuser[0];
   assign starts     = req_tuser[1];
   assign b          = req_tdata;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   always_comb begin
      first      = starts || count_ff == 3'd0;
      armed_base = first ? 1'b0 : armed_ff;

      if (first) count_in = 3'd1;
      else if (count_ff != 3'd7) count_in = count_ff + 3'd1;
      else count_in = count_ff;

      xor_in = first ? b : (xor_ff ^ b);

      for (int i = 0; i < 3; i++) begin
         header_in[i] = (count_in == 3'(i + 1)) ? b : header_ff[i];
      end

      // size the command from the updated header
      al  = addr_len(header_in[0]);
      il1 = instr_len(header_in[1]);
      il2 = instr_len(header_in[2]);
      complete = 1'b0;
      if (al == 2'd1) begin
         complete = count_in >= 3'd2 && il1 != 2'd0 && count_in == ({1'b0, il1} + 3'd1);
      end else if (al == 2'd2) begin
         complete = count_in >= 3'd3 && il2 != 2'd0 && count_in == ({1'b0, il2} + 3'd2);
      end

      if (header_in[0] == BYTE_BROADCAST) begin
         pkt_addr = 14'd0;
         pkt_kind = KIND_BROADCAST;
      end else if (header_in[0] == BYTE_IDLE) begin
         pkt_addr = {6'd0, BYTE_IDLE};
         pkt_kind = KIND_IDLE;
      end else if (al == 2'd1) begin
         pkt_addr = {6'd0, header_in[0]};
         pkt_kind = KIND_SHORT;
      end else begin
         pkt_addr = {header_in[0][5:0] & LONG_HI_MASK[5:0], header_in[1]};
         pkt_kind = KIND_LONG;
      end

      arm = !armed_base && complete && pkt_kind == own_kind_ff && pkt_addr == own_addr_ff;

      // defaults hold state, result word all zero
      armed_in        = armed_ff;
      toggle_in       = toggle_ff;
      held_half_in    = held_half_ff;
      held_payload_in = held_payload_ff;
      rsp_tdata_in    = 8'd0;
      rsp_tuser_in    = 3'd0;

      if (action == ACT_END) begin
         armed_in = 1'b0;
         if (armed_ff && count_ff >= 3'd2 && xor_ff == 8'd0) begin
            rsp_tuser_in = {held_half_ff, 1'b1, 1'b0};
            rsp_tdata_in = held_payload_ff;
         end
      end else begin
         armed_in = armed_base;
         if (arm) begin
            held_half_in    = toggle_ff;
            held_payload_in = toggle_ff ? own_addr_ff[7:0] : {2'b00, own_addr_ff[13:8]};
            toggle_in       = !toggle_ff;
            armed_in        = 1'b1;
            rsp_tuser_in    = {toggle_ff, 1'b0, 1'b1};
            rsp_tdata_in    = held_payload_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff     <= OWN_ADDRESS_RESET;
         own_kind_ff     <= KIND_SHORT;
         count_ff        <= 3'd0;
         xor_ff          <= 8'd0;
         armed_ff        <= 1'b0;
         toggle_ff       <= 1'b0;
         held_half_ff    <= 1'b0;
         held_payload_ff <= 8'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_OWN_ADDRESS:      own_addr_ff <= csr_data;
               CSR_OWN_ADDRESS_KIND: own_kind_ff <= csr_data[1:0];
               default: ;
            endcase
         end
         if (accept) begin
            armed_ff        <= armed_in;
            toggle_ff       <= toggle_in;
            held_half_ff    <= held_half_in;
            held_payload_ff <= held_payload_in;
            if (action == ACT_BYTE) begin
               count_ff <= count_in;
               xor_ff   <= xor_in;
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // header bytes and the result word carry no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
         if (action == ACT_BYTE) begin
            for (int i = 0; i < 3; i++) begin
               header_ff[i] <= header_in[i];
            end
         end
      end
   end

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_tuser_ff[0] && rsp_tuser_ff[1]))
      else $error("armed_now and respond in the same word");

   a_end_disarms: assert property (@(posedge clock) disable iff (reset)
      accept && action == ACT_END |=> !armed_ff)
      else $error("packet end left a reply armed");

   a_idle_word_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tuser_ff[0] && !rsp_tuser_ff[1]
         |-> rsp_tdata_ff == 8'd0 && !rsp_tuser_ff[2])
      else $error("address half on a word with no reply");

   a_arm_toggles: assert property (@(posedge clock) disable iff (reset)
      accept && action == ACT_BYTE && arm |=> toggle_ff != $past(toggle_ff) && armed_ff)
      else $error("arming did not flip the half");

endmodule

// ===== sim/tb.sv =====
module tb;
   import dccpr_pkg::*;

   typedef struct packed {
      logic       armed_now;
      logic       respond;
      logic       low_half;
      logic [7:0] payload;
   } reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] packet_byte
   logic [1:0]  req_tuser = 2'd0;   // [0] action, [1] starts_packet
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // [7:0] adr_payload
   logic [2:0]  rsp_tuser;          // [0] armed_now, [1] respond, [2] adr_low_half
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [13:0] csr_data = 14'd0;

   // recognizer state as the testbench sees it
   logic [7:0]  pk_hdr [3];
   logic [2:0]  pk_count;
   logic [7:0]  pk_xor;
   logic        pk_armed;
   logic        next_half;
   logic        held_half;
   logic [7:0]  held_pay;
   logic [13:0] own_addr;
   logic [1:0]  own_kind;

   reply_type replies_due [$];
   int     errors = 0;
   int     words_sent = 0;
   int     burst_left = 0;
   int     hold_requests = 0;
   int     hold_served = 0;
   int     hold_left = 0;
   int     rsp_mode = 0;
   int     rsp_mode_left = 0;

   dcc_packet_recognizer_arm DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   function automatic int addr_bytes(input logic [7:0] b0);
      if (!b0[7] || b0 == BYTE_IDLE) return 1;
      if (b0 >= LONG_FIRST && b0 <= LONG_LAST) return 2;
      return 0;
   endfunction

   function automatic int op_bytes(input logic [7:0] op);
      case (op[7:5])
         3'b000: return op[4] ? 2 : 0;
         3'b001: begin
            if (op == OP_CV_SHORT) return 2;
            if (op == OP_ANALOG) return 3;
            return 0;
         end
         3'b010, 3'b011, 3'b100, 3'b101: return 1;
         3'b110: begin
            if (op == OP_CONSIST) return 3;
            if (op == OP_BIN_SHORT) return 2;
            if (op >= OP_FUNC_LO && op <= OP_FUNC_HI) return 2;
            return 0;
         end
         default: begin
            if (op[4]) return 2;
            if (op == OP_CV_VERIFY || op == OP_CV_BIT || op == OP_CV_WRITE) return 3;
            return 0;
         end
      endcase
   endfunction

   // next byte would be the xor byte of a sized command
   function automatic logic command_done();
      int al;
      int il;
      al = addr_bytes(pk_hdr[0]);
      if (al == 0 || int'(pk_count) < al + 1) return 1'b0;
      il = op_bytes(pk_hdr[2'(al)]);
      if (il == 0) return 1'b0;
      return (al + il) == int'(pk_count);
   endfunction

   function automatic logic address_hit();
      logic [13:0] a;
      logic [1:0]  k;
      if (pk_hdr[0] == BYTE_BROADCAST) begin
         a = 14'd0;
         k = KIND_BROADCAST;
      end else if (pk_hdr[0] == BYTE_IDLE) begin
         a = 14'hFF;
         k = KIND_IDLE;
      end else if (addr_bytes(pk_hdr[0]) == 1) begin
         a = {6'd0, pk_hdr[0]};
         k = KIND_SHORT;
      end else begin
         a = {pk_hdr[0][5:0], pk_hdr[1]};
         k = KIND_LONG;
      end
      return k == own_kind && a == own_addr;
   endfunction

   task automatic clear_packet_state();
      own_addr  = OWN_ADDRESS_RESET;
      own_kind  = KIND_SHORT;
      pk_count  = 3'd0;
      pk_xor    = 8'd0;
      pk_armed  = 1'b0;
      next_half = 1'b0;
      held_half = 1'b0;
      held_pay  = 8'd0;
   endtask

   task automatic decode_word(input logic act, input logic [7:0] b, input logic first,
                              output reply_type r);
      r = '0;
      if (act == ACT_END) begin
         if (pk_armed) begin
            pk_armed = 1'b0;
            if (pk_count >= 3'd2 && pk_xor == 8'd0) begin
               r.respond  = 1'b1;
               r.low_half = held_half;
               r.payload  = held_pay;
            end
         end
      end else begin
         if (first || pk_count == 3'd0) begin
            pk_count = 3'd1;
            pk_xor   = b;
            pk_armed = 1'b0;
         end else begin
            if (pk_count < 3'd7) pk_count = pk_count + 3'd1;
            pk_xor = pk_xor ^ b;
         end
         if (pk_count <= 3'd3) pk_hdr[2'(pk_count - 3'd1)] = b;
         if (!pk_armed && command_done() && address_hit()) begin
            held_half = next_half;
            held_pay  = next_half ? own_addr[7:0] : {2'b00, own_addr[13:8]};
            next_half = ~next_half;
            pk_armed  = 1'b1;
            r.armed_now = 1'b1;
            r.low_half  = held_half;
            r.payload   = held_pay;
         end
      end
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s expected %0h actual %0h", name, want, got);
         errors++;
      end
   endtask

   // scoreboard: check the rsp word first, then predict from the req word
   always @(posedge clock) begin
      reply_type got;
      reply_type want;
      reply_type r;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser[0], rsp_tuser[1], rsp_tuser[2], rsp_tdata};
            if (replies_due.size() == 0) begin
               $error("rsp word with nothing expected: %h", got);
               errors++;
            end else begin
               want = replies_due.pop_front();
               check_field("armed_now", int'(want.armed_now), int'(got.armed_now));
               check_field("respond", int'(want.respond), int'(got.respond));
               check_field("adr_low_half", int'(want.low_half), int'(got.low_half));
               check_field("adr_payload", int'(want.payload), int'(got.payload));
            end
         end
         if (req_tvalid && req_tready) begin
            decode_word(req_tuser[0], req_tdata, req_tuser[1], r);
            replies_due.push_back(r);
         end
      end
   end

   // receiver: random stall modes, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= 90;
         rsp_tready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_mode_left == 0) begin
            rsp_mode      <= $urandom_range(0, 3);
            rsp_mode_left <= $urandom_range(16, 200);
         end else begin
            rsp_mode_left <= rsp_mode_left - 1;
         end
         case (rsp_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 1) == 0);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // entered and left at a falling edge
   task automatic send_word(input logic act, input logic [7:0] b, input logic first);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= {first, act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (replies_due.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_regs(input logic [13:0] a, input logic [1:0] k);
      csr_valid <= 1'b1;
      csr_index <= CSR_OWN_ADDRESS;
      csr_data  <= a;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      own_addr = a;
      @(negedge clock);
      csr_index <= CSR_OWN_ADDRESS_KIND;
      csr_data  <= {12'd0, k};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      own_kind = k;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // mostly well-formed packets aimed at our own address, some noise
   task automatic send_packet();
      logic [7:0] body [$];
      logic [7:0] sum;
      logic [7:0] op;
      int         pick;
      int         n_ops;
      if ($urandom_range(0, 99) < 8) begin
         repeat ($urandom_range(1, 4))
            send_word(1'($urandom), 8'($urandom), 1'($urandom));
         return;
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         case (own_kind)
            KIND_SHORT: body.push_back(own_addr[7:0]);
            KIND_LONG: begin
               body.push_back(LONG_FIRST | {2'b00, own_addr[13:8]});
               body.push_back(own_addr[7:0]);
            end
            KIND_BROADCAST: body.push_back(BYTE_BROADCAST);
            default: body.push_back(BYTE_IDLE);
         endcase
      end else if (pick == 7) begin
         body.push_back(8'($urandom_range(0, 127)));
      end else if (pick == 8) begin
         body.push_back(8'($urandom_range(LONG_FIRST, LONG_LAST)));
         body.push_back(8'($urandom));
      end else begin
         body.push_back(8'($urandom));
      end
      case ($urandom_range(0, 11))
         0: op = {4'h1, 4'($urandom)};
         1: op = {2'b01, 6'($urandom)};
         2: op = ($urandom_range(0, 1) != 0) ? OP_CV_SHORT : OP_ANALOG;
         3: op = {3'b100, 5'($urandom)};
         4: op = {3'b101, 5'($urandom)};
         5: op = OP_CONSIST;
         6: op = OP_BIN_SHORT;
         7: op = 8'($urandom_range(OP_FUNC_LO, OP_FUNC_HI));
         8: op = {4'hF, 4'($urandom)};
         9: begin
            case ($urandom_range(0, 2))
               0: op = OP_CV_VERIFY;
               1: op = OP_CV_BIT;
               default: op = OP_CV_WRITE;
            endcase
         end
         default: op = 8'($urandom);
      endcase
      body.push_back(op);
      n_ops = op_bytes(op);
      if (n_ops == 0) n_ops = $urandom_range(1, 4);
      repeat (n_ops - 1) body.push_back(8'($urandom));
      sum = 8'd0;
      foreach (body[i]) sum = sum ^ body[i];
      body.push_back(($urandom_range(0, 99) < 85) ? sum : 8'($urandom));
      if ($urandom_range(0, 99) < 5) body.push_back(8'($urandom));
      foreach (body[i])
         send_word(ACT_BYTE, body[i],
                   (i == 0) ? ($urandom_range(0, 99) < 94) : ($urandom_range(0, 99) < 2));
      if ($urandom_range(0, 99) < 92) send_word(ACT_END, 8'($urandom), 1'($urandom));
   endtask

   task automatic run_phase(input logic [13:0] a, input logic [1:0] k, input int words);
      int start;
      settle();
      write_regs(a, k);
      start = words_sent;
      while (words_sent - start < words) send_packet();
   endtask

   // reset settings: short address 3
   task automatic test_directed();
      // first word after reset without starts_packet, speed command, good xor
      send_word(ACT_BYTE, 8'h03, 1'b0);
      send_word(ACT_BYTE, 8'h60, 1'b0);
      send_word(ACT_BYTE, 8'h63, 1'b0);
      send_word(ACT_END, 8'h00, 1'b0);
      // cv short form takes the low half; a trailing byte after arming is ignored
      send_word(ACT_BYTE, 8'h03, 1'b1);
      send_word(ACT_BYTE, OP_CV_SHORT, 1'b0);
      send_word(ACT_BYTE, 8'h05, 1'b0);
      send_word(ACT_BYTE, 8'h03 ^ OP_CV_SHORT ^ 8'h05, 1'b0);
      send_word(ACT_BYTE, 8'h00, 1'b0);
      send_word(ACT_END, 8'hFF, 1'b1);
      // armed but xor fails at packet end
      send_word(ACT_BYTE, 8'h03, 1'b1);
      send_word(ACT_BYTE, 8'h80, 1'b0);
      send_word(ACT_BYTE, 8'h00, 1'b0);
      send_word(ACT_END, 8'h5A, 1'b0);
      // unsized opcode, count saturates past seven bytes
      send_word(ACT_BYTE, 8'h03, 1'b1);
      send_word(ACT_BYTE, 8'h20, 1'b0);
      send_word(ACT_BYTE, 8'hFF, 1'b0);
      send_word(ACT_BYTE, 8'h00, 1'b0);
      send_word(ACT_BYTE, 8'h7F, 1'b0);
      send_word(ACT_BYTE, 8'h80, 1'b0);
      send_word(ACT_BYTE, 8'hFF, 1'b0);
      send_word(ACT_BYTE, 8'h01, 1'b0);
      send_word(ACT_END, 8'h00, 1'b0);
      settle();
   endtask

   task automatic test_backpressure();
      int start;
      hold_requests++;
      start = words_sent;
      while (words_sent - start < 60) send_packet();
      settle();
   endtask

   task automatic test_short_address();
      run_phase(14'd127, KIND_SHORT, 135);
      run_phase(14'd1, KIND_SHORT, 135);
      run_phase(14'($urandom_range(1, 127)), KIND_SHORT, 135);
      run_phase(14'd0, KIND_SHORT, 135);
   endtask

   task automatic test_long_address();
      run_phase(14'd0, KIND_LONG, 135);
      run_phase(14'h27FF, KIND_LONG, 135);
      run_phase(14'h3FFF, KIND_LONG, 135);
      run_phase(14'($urandom_range(0, 14'h27FF)), KIND_LONG, 135);
   endtask

   task automatic test_special_address();
      run_phase(14'd0, KIND_BROADCAST, 135);
      run_phase(14'hFF, KIND_IDLE, 135);
      run_phase(14'h3FFF, KIND_IDLE, 135);
   endtask

   initial begin
      clear_packet_state();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_backpressure();
      test_short_address();
      test_long_address();
      test_special_address();
      settle();
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
